### hw/rtl/mups_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mups_pkg
// Shared types, codes and constants for the MIDI UART port sequencer.
// ----------------------------------------------------------------------------
package mups_pkg;

    // Defaults for the top-level parameters.
    localparam int TIMER_BITS_DEF    = 16;
    localparam int CHANNEL_COUNT_DEF = 16;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Port command and status bytes.
    localparam logic [7:0] BYTE_RESET      = 8'hFF;
    localparam logic [7:0] BYTE_UART_MODE  = 8'h3F;
    localparam logic [7:0] BYTE_ACK        = 8'hFE;
    localparam logic [7:0] ST_PROGRAM      = 8'hC0;
    localparam logic [7:0] ST_CONTROL      = 8'hB0;
    localparam logic [7:0] CC_NOTES_OFF    = 8'd123;
    localparam logic [7:0] CC_SOUNDS_OFF   = 8'd120;
    localparam logic [7:0] CC_CTRL_OFF     = 8'd121;

    // Configuration reset values.
    localparam logic [15:0] CTL_TIMEOUT_RST  = 16'd250;
    localparam logic [15:0] DATA_TIMEOUT_RST = 16'd25;
    localparam logic [7:0]  META_STATUS_RST  = 8'hFF;
    localparam logic [3:0]  SKIP_CHAN_RST    = 4'd9;
    localparam logic [6:0]  INIT_PROG_RST    = 7'd0;

    typedef enum logic [1:0] {
        CMD_POLL  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_EVENT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WDATA = 2'd2,
        ACT_WCTRL = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        CFG_CTL_TIMEOUT  = 3'd0,
        CFG_DATA_TIMEOUT = 3'd1,
        CFG_META_STATUS  = 3'd2,
        CFG_SKIP_CHAN    = 3'd3,
        CFG_INIT_PROG    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_WAIT  = 4'd1,
        PH_RST_ACK   = 4'd2,
        PH_RST_FLUSH = 4'd3,
        PH_UART      = 4'd4,
        PH_PROG      = 4'd5,
        PH_CL_NOTES  = 4'd6,
        PH_CL_SOUNDS = 4'd7,
        PH_CL_CTRL   = 4'd8,
        PH_EVENT     = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        PW_WAIT  = 2'd0,
        PW_READY = 2'd1,
        PW_FAIL  = 2'd2
    } pw_t;

    typedef struct packed {
        logic [15:0] ctl_timeout;
        logic [15:0] data_timeout;
        logic [7:0]  meta_status;
        logic [3:0]  skip_chan;
        logic [6:0]  init_prog;
    } cfg_t;

    // One classified poll as it travels through the queue.
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] byte_value;
        logic       event_end;
        logic       tx_full;
        logic       rx_empty;
        logic       ack_seen;
        logic       meta_match;
        logic       tick;
    } item_t;

    typedef struct packed {
        act_t       port_action;
        logic [7:0] port_byte;
        logic       accepted;
        logic       request_done;
        logic       request_ok;
        logic       device_good;
    } res_t;

endpackage
`default_nettype wire

### hw/rtl/mups_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mups_front
// Takes input beats, decodes the command and pre-compares the bytes that the
// back end tests, and pushes the classified poll into the queue.
// ----------------------------------------------------------------------------
module mups_front
    import mups_pkg::*;
(
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic [1:0] command,
    input  wire logic [7:0] byte_value,
    input  wire logic       event_end,
    input  wire logic       tx_full,
    input  wire logic       rx_empty,
    input  wire logic [7:0] rx_byte,
    input  wire logic       tick,
    input  wire cfg_t       cfg,
    input  wire logic       q_ready,
    output logic            q_push,
    output item_t           q_item
);

    assign item_ready = q_ready;
    assign q_push     = item_valid && q_ready;

    always_comb
    begin
        q_item.cmd        = cmd_t'(command);
        q_item.byte_value = byte_value;
        q_item.event_end  = event_end;
        q_item.tx_full    = tx_full;
        q_item.rx_empty   = rx_empty;
        q_item.ack_seen   = (rx_byte == BYTE_ACK);
        q_item.meta_match = (byte_value == cfg.meta_status);
        q_item.tick       = tick;
    end

endmodule
`default_nettype wire

### hw/rtl/mups_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mups_queue
// Short first-in first-out queue of classified polls between the front and
// the back end.
// ----------------------------------------------------------------------------
module mups_queue
    import mups_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       push_ready,
    input  wire logic  pop,
    output logic       pop_valid,
    output item_t      pop_item
);

    item_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg;
    logic [QUEUE_CW-1:0]  count_next;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QUEUE_AW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + QUEUE_CW'(1);
            2'b01:   count_next = count_reg - QUEUE_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/mups_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mups_back
// Port sequencer state machine. Executes one queued poll per cycle unless the
// output register is stalled, and holds the resulting beat in that register.
// ----------------------------------------------------------------------------
module mups_back
    import mups_pkg::*;
#(
    parameter int TIMER_BITS    = TIMER_BITS_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire item_t q_item,
    output logic       q_pop,
    output logic       result_valid,
    input  wire logic  result_ready,
    output res_t       result
);

    localparam logic [4:0] CHAN_LIMIT = 5'(CHANNEL_COUNT);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [TIMER_BITS-1:0] timeout_reg;
    logic [TIMER_BITS-1:0] timeout_next;
    logic [3:0]            chan_reg;
    logic [3:0]            chan_next;
    logic [1:0]            step_reg;
    logic [1:0]            step_next;
    logic                  good_reg;
    logic                  good_next;
    logic                  in_event_reg;
    logic                  in_event_next;
    logic                  skip_meta_reg;
    logic                  skip_meta_next;
    logic [7:0]            held_byte_reg;
    logic [7:0]            held_byte_next;
    logic                  valid_reg;
    logic                  valid_next;
    res_t                  res_reg;
    res_t                  res_next;
    logic                  fire;

    logic [TIMER_BITS-1:0] ctl_load;
    logic [TIMER_BITS-1:0] data_load;

    // First channel at or after start that is not skipped. The result is
    // below CHAN_LIMIT only when such a channel exists.
    function automatic logic [4:0] find_chan(input logic [4:0] start, input logic [3:0] skip);
        find_chan = (start == {1'b0, skip}) ? start + 5'd1 : start;
    endfunction

    assign ctl_load  = TIMER_BITS'(cfg.ctl_timeout);
    assign data_load = TIMER_BITS'(cfg.data_timeout);

    assign fire         = q_valid && (!valid_reg || result_ready);
    assign q_pop        = fire;
    assign result_valid = valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        logic       expired;
        logic       rst_end;
        logic       rst_ok;
        pw_t        pw;
        logic [4:0] cand;

        phase_next     = phase_reg;
        timeout_next   = timeout_reg;
        chan_next      = chan_reg;
        step_next      = step_reg;
        good_next      = good_reg;
        in_event_next  = in_event_reg;
        skip_meta_next = skip_meta_reg;
        held_byte_next = held_byte_reg;
        res_next       = '0;
        expired        = 1'b0;
        rst_end        = 1'b0;
        rst_ok         = 1'b0;
        cand           = '0;
        pw             = PW_WAIT;

        if (phase_reg != PH_IDLE)
        begin
            if (q_item.tick)
            begin
                if (timeout_reg == '0)
                begin
                    expired = 1'b1;
                end
                else
                begin
                    timeout_next = timeout_reg - TIMER_BITS'(1);
                end
            end

            // Drain received bytes first, then wait for room in the transmitter.
            if (expired)
            begin
                pw = PW_FAIL;
            end
            else if (!q_item.rx_empty || q_item.tx_full)
            begin
                pw = PW_WAIT;
            end
            else
            begin
                pw = PW_READY;
            end

            case (phase_reg)
                PH_RST_WAIT:
                begin
                    if (!q_item.rx_empty && !expired)
                    begin
                        res_next.port_action = ACT_READ;
                    end
                    if (pw != PW_WAIT)
                    begin
                        res_next.port_action = ACT_WCTRL;
                        res_next.port_byte   = BYTE_RESET;
                        phase_next           = PH_RST_ACK;
                    end
                end
                PH_RST_ACK:
                begin
                    if (!q_item.rx_empty)
                    begin
                        res_next.port_action = ACT_READ;
                    end
                    if (!q_item.rx_empty && q_item.ack_seen)
                    begin
                        phase_next = PH_RST_FLUSH;
                    end
                    else if (expired)
                    begin
                        rst_end = 1'b1;
                    end
                end
                PH_RST_FLUSH:
                begin
                    if (q_item.rx_empty)
                    begin
                        rst_end = 1'b1;
                        rst_ok  = 1'b1;
                    end
                    else if (expired)
                    begin
                        rst_end = 1'b1;
                    end
                    else
                    begin
                        res_next.port_action = ACT_READ;
                    end
                end
                PH_UART:
                begin
                    if (!q_item.rx_empty && !expired)
                    begin
                        res_next.port_action = ACT_READ;
                    end
                    if (pw == PW_FAIL)
                    begin
                        res_next.request_done = 1'b1;
                        phase_next            = PH_IDLE;
                    end
                    else if (pw == PW_READY)
                    begin
                        res_next.port_action = ACT_WCTRL;
                        res_next.port_byte   = BYTE_UART_MODE;
                        good_next            = 1'b1;
                        cand                 = find_chan(5'd0, cfg.skip_chan);
                        if (cand < CHAN_LIMIT)
                        begin
                            chan_next    = cand[3:0];
                            step_next    = 2'd0;
                            timeout_next = data_load;
                            phase_next   = PH_PROG;
                        end
                        else
                        begin
                            res_next.request_done = 1'b1;
                            res_next.request_ok   = 1'b1;
                            phase_next            = PH_IDLE;
                        end
                    end
                end
                PH_PROG:
                begin
                    if (!q_item.rx_empty && !expired)
                    begin
                        res_next.port_action = ACT_READ;
                    end
                    if (pw == PW_FAIL)
                    begin
                        good_next             = 1'b0;
                        res_next.request_done = 1'b1;
                        phase_next            = PH_IDLE;
                    end
                    else if (pw == PW_READY)
                    begin
                        res_next.port_action = ACT_WDATA;
                        if (step_reg == 2'd0)
                        begin
                            res_next.port_byte = ST_PROGRAM | {4'd0, chan_reg};
                            step_next          = 2'd1;
                            timeout_next       = data_load;
                        end
                        else
                        begin
                            res_next.port_byte = {1'b0, cfg.init_prog};
                            cand = find_chan({1'b0, chan_reg} + 5'd1, cfg.skip_chan);
                            if (cand < CHAN_LIMIT)
                            begin
                                chan_next    = cand[3:0];
                                step_next    = 2'd0;
                                timeout_next = data_load;
                            end
                            else
                            begin
                                res_next.request_done = 1'b1;
                                res_next.request_ok   = 1'b1;
                                phase_next            = PH_IDLE;
                            end
                        end
                    end
                end
                PH_CL_NOTES, PH_CL_SOUNDS, PH_CL_CTRL:
                begin
                    if (!q_item.rx_empty && !expired)
                    begin
                        res_next.port_action = ACT_READ;
                    end
                    if (pw == PW_FAIL)
                    begin
                        // Drop the rest of the close writes but still reset.
                        good_next    = 1'b0;
                        step_next    = 2'd1;
                        timeout_next = ctl_load;
                        phase_next   = PH_RST_WAIT;
                    end
                    else if (pw == PW_READY)
                    begin
                        res_next.port_action = ACT_WDATA;
                        timeout_next         = data_load;
                        if (step_reg == 2'd0)
                        begin
                            res_next.port_byte = ST_CONTROL | {4'd0, chan_reg};
                            step_next          = 2'd1;
                        end
                        else if (step_reg == 2'd1)
                        begin
                            if (phase_reg == PH_CL_NOTES)
                            begin
                                res_next.port_byte = CC_NOTES_OFF;
                            end
                            else if (phase_reg == PH_CL_SOUNDS)
                            begin
                                res_next.port_byte = CC_SOUNDS_OFF;
                            end
                            else
                            begin
                                res_next.port_byte = CC_CTRL_OFF;
                            end
                            step_next = 2'd2;
                        end
                        else
                        begin
                            res_next.port_byte = 8'd0;
                            step_next          = 2'd0;
                            if (phase_reg == PH_CL_NOTES)
                            begin
                                phase_next = PH_CL_SOUNDS;
                            end
                            else if (phase_reg == PH_CL_SOUNDS)
                            begin
                                phase_next = PH_CL_CTRL;
                            end
                            else if (({1'b0, chan_reg} + 5'd1) < CHAN_LIMIT)
                            begin
                                chan_next  = chan_reg + 4'd1;
                                phase_next = PH_CL_NOTES;
                            end
                            else
                            begin
                                step_next    = 2'd1;
                                timeout_next = ctl_load;
                                phase_next   = PH_RST_WAIT;
                            end
                        end
                    end
                end
                PH_EVENT:
                begin
                    if (!q_item.rx_empty && !expired)
                    begin
                        res_next.port_action = ACT_READ;
                    end
                    if (pw != PW_WAIT)
                    begin
                        if (pw == PW_READY)
                        begin
                            res_next.port_action = ACT_WDATA;
                            res_next.port_byte   = held_byte_reg;
                        end
                        else
                        begin
                            good_next = 1'b0;
                        end
                        if (step_reg[0])
                        begin
                            res_next.request_done = 1'b1;
                            res_next.request_ok   = (pw == PW_READY);
                            in_event_next         = 1'b0;
                            skip_meta_next        = 1'b0;
                        end
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (rst_end)
            begin
                if (step_reg == 2'd0)
                begin
                    if (rst_ok)
                    begin
                        timeout_next = ctl_load;
                        phase_next   = PH_UART;
                    end
                    else
                    begin
                        res_next.request_done = 1'b1;
                        phase_next            = PH_IDLE;
                    end
                end
                else
                begin
                    res_next.request_done = 1'b1;
                    res_next.request_ok   = rst_ok && good_next;
                    phase_next            = PH_IDLE;
                end
            end
        end
        else
        begin
            case (q_item.cmd)
                CMD_OPEN:
                begin
                    res_next.accepted = 1'b1;
                    in_event_next     = 1'b0;
                    skip_meta_next    = 1'b0;
                    step_next         = 2'd0;
                    timeout_next      = ctl_load;
                    phase_next        = PH_RST_WAIT;
                end
                CMD_CLOSE:
                begin
                    res_next.accepted = 1'b1;
                    in_event_next     = 1'b0;
                    skip_meta_next    = 1'b0;
                    if (!good_reg)
                    begin
                        res_next.request_done = 1'b1;
                    end
                    else
                    begin
                        chan_next    = 4'd0;
                        step_next    = 2'd0;
                        timeout_next = data_load;
                        phase_next   = PH_CL_NOTES;
                    end
                end
                CMD_EVENT:
                begin
                    res_next.accepted = 1'b1;
                    if (!in_event_reg)
                    begin
                        in_event_next  = 1'b1;
                        skip_meta_next = good_reg && q_item.meta_match;
                    end
                    if (skip_meta_next || !good_reg)
                    begin
                        if (q_item.event_end)
                        begin
                            res_next.request_done = 1'b1;
                            res_next.request_ok   = skip_meta_next;
                            in_event_next         = 1'b0;
                            skip_meta_next        = 1'b0;
                        end
                    end
                    else
                    begin
                        held_byte_next = q_item.byte_value;
                        step_next      = {1'b0, q_item.event_end};
                        timeout_next   = data_load;
                        phase_next     = PH_EVENT;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        res_next.device_good = good_next;
    end

    always_comb
    begin
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timeout_reg   <= '0;
            chan_reg      <= '0;
            step_reg      <= '0;
            good_reg      <= 1'b0;
            in_event_reg  <= 1'b0;
            skip_meta_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fire)
            begin
                phase_reg     <= phase_next;
                timeout_reg   <= timeout_next;
                chan_reg      <= chan_next;
                step_reg      <= step_next;
                good_reg      <= good_next;
                in_event_reg  <= in_event_next;
                skip_meta_reg <= skip_meta_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            held_byte_reg <= held_byte_next;
            res_reg       <= res_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/midi_uart_port_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_uart_port_sequencer
// Host-side sequencer for a MIDI UART port: open, close and event bytes,
// one port status poll per beat.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat is one poll: a host request (command, byte_value,
// event_end) together with a sample of the port status (tx_full, rx_empty,
// rx_byte, tick). Every input beat yields exactly one result beat telling
// the host which port access to perform (port_action, port_byte), whether
// the request was taken (accepted; 0 means offer it again), and whether an
// open, close or event finished (request_done, request_ok), plus the
// current device_good flag.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no poll is in flight.
// An accepted input beat is written into the queue, and the state machine
// then executes it into the output register, where the receiver takes it.
// Throughput is one beat per clock while the receiver keeps taking beats: a
// two-entry queue separates the classifying front end from the sequencer
// state machine, which retires one poll per cycle into an output register.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and item_ready drops once two beats wait in the queue.
// Reset clears the sequencer to idle with device_good low, empties the
// queue and restores the configuration defaults.
// ----------------------------------------------------------------------------
module midi_uart_port_sequencer
    import mups_pkg::*;
#(
    parameter int TIMER_BITS    = TIMER_BITS_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  byte_value,
    input  wire logic        event_end,
    input  wire logic        tx_full,
    input  wire logic        rx_empty,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        tick,

    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       port_action,
    output logic [7:0]       port_byte,
    output logic             accepted,
    output logic             request_done,
    output logic             request_ok,
    output logic             device_good
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_push;
    logic  q_ready;
    item_t q_in_item;
    logic  q_pop;
    logic  q_valid;
    item_t q_out_item;
    res_t  result;

    // Configuration writes land directly; an index past the list is ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CTL_TIMEOUT:  cfg_next.ctl_timeout  = cfg_data;
                CFG_DATA_TIMEOUT: cfg_next.data_timeout = cfg_data;
                CFG_META_STATUS:  cfg_next.meta_status  = cfg_data[7:0];
                CFG_SKIP_CHAN:    cfg_next.skip_chan    = cfg_data[3:0];
                CFG_INIT_PROG:    cfg_next.init_prog    = cfg_data[6:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ctl_timeout  <= CTL_TIMEOUT_RST;
            cfg_reg.data_timeout <= DATA_TIMEOUT_RST;
            cfg_reg.meta_status  <= META_STATUS_RST;
            cfg_reg.skip_chan    <= SKIP_CHAN_RST;
            cfg_reg.init_prog    <= INIT_PROG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accepts input beats and classifies them.
    mups_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .command    (command),
        .byte_value (byte_value),
        .event_end  (event_end),
        .tx_full    (tx_full),
        .rx_empty   (rx_empty),
        .rx_byte    (rx_byte),
        .tick       (tick),
        .cfg        (cfg_reg),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_item     (q_in_item)
    );

    // Queue that lets the front keep accepting while the back end stalls.
    mups_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_out_item)
    );

    // Back end: the sequencer itself and the output register.
    mups_back #(
        .TIMER_BITS    (TIMER_BITS),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_out_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign port_action  = result.port_action;
    assign port_byte    = result.port_byte;
    assign accepted     = result.accepted;
    assign request_done = result.request_done;
    assign request_ok   = result.request_ok;
    assign device_good  = result.device_good;

endmodule
`default_nettype wire

### hw/rtl/mups_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mups_checker
// Port-level checks for the MIDI UART port sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mups_checker
    import mups_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [1:0] port_action,
    input wire logic [7:0] port_byte,
    input wire logic       accepted,
    input wire logic       request_done,
    input wire logic       request_ok
);

    // A stalled result beat must stay offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    // Success is only reported on a finishing beat.
    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && request_ok |-> request_done)
        else $error("request_ok without request_done");

    // No byte is shown unless the port is written.
    a_byte_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (port_action == ACT_NONE || port_action == ACT_READ)
        |-> port_byte == 8'd0)
        else $error("port_byte set without a write");

    // A beat that takes a host request never touches the port.
    a_accept_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && accepted |-> port_action == ACT_NONE)
        else $error("port access on an accepting beat");

    // Control writes are only the reset and the mode change.
    a_ctrl_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && port_action == ACT_WCTRL
        |-> port_byte == BYTE_RESET || port_byte == BYTE_UART_MODE)
        else $error("unexpected control byte");

endmodule

bind midi_uart_port_sequencer mups_checker u_checker (.*);
`default_nettype wire

### tb/midi_uart_port_sequencer_chk.sv
// ----------------------------------------------------------------------------
// midi_uart_port_sequencer_chk
// Passive scoreboard for the MIDI UART port sequencer. It keeps its own copy
// of the sequencer state and configuration and works out the result of every
// accepted poll beat. It compares each result beat, field by field, with the
// oldest pending prediction. It also reports its view of the sequencer to the
// stimulus side: how many results are pending and whether a request would be
// taken.
// ----------------------------------------------------------------------------
module midi_uart_port_sequencer_chk
    import mups_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  byte_value,
    input  logic        event_end,
    input  logic        tx_full,
    input  logic        rx_empty,
    input  logic [7:0]  rx_byte,
    input  logic        tick,

    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [1:0]  port_action,
    input  logic [7:0]  port_byte,
    input  logic        accepted,
    input  logic        request_done,
    input  logic        request_ok,
    input  logic        device_good,

    output int          fail_count,
    output int          pending,
    output logic        seq_idle
);

    // Configuration copy.
    logic [15:0] ctl_to;
    logic [15:0] data_to;
    logic [7:0]  meta_st;
    logic [3:0]  skip_ch;
    logic [6:0]  init_prog;

    // Sequencer state copy.
    phase_t      ph;
    logic [15:0] t_left;
    logic [3:0]  chan;
    logic [2:0]  step;
    logic        good;
    logic        in_event;
    logic        skip_meta;
    logic [7:0]  held;
    logic        held_v;

    res_t        port_access_q[$];
    int          errors = 0;

    assign fail_count = errors;

    // First channel at or after start that is not left out.
    function automatic logic next_chan(input int start, output logic [3:0] ch);
        next_chan = 1'b0;
        ch = 4'd0;
        for (int i = start; i < CHANNEL_COUNT && i < 16; i++) begin
            if (!next_chan && i != int'(skip_ch)) begin
                ch = 4'(i);
                next_chan = 1'b1;
            end
        end
    endfunction

    // Drain received bytes first, then wait for room in the transmitter.
    function automatic pw_t tx_gate(input logic rxe, input logic txf, input logic expd);
        if (!rxe)
            return expd ? PW_FAIL : PW_WAIT;
        if (expd)
            return PW_FAIL;
        return txf ? PW_WAIT : PW_READY;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // One poll beat through the sequencer copy.
    task automatic advance_sequencer(output res_t r);
        act_t       act;
        logic [7:0] pb;
        logic       acc;
        logic       done;
        logic       ok;
        logic       expd;
        logic       rst_end;
        logic       rst_ok;
        logic       reload;
        logic [3:0] ch;
        pw_t        pw;
        cmd_t       c;

        act = ACT_NONE;
        pb = 8'd0;
        acc = 1'b0;
        done = 1'b0;
        ok = 1'b0;
        expd = 1'b0;
        rst_end = 1'b0;
        rst_ok = 1'b0;
        c = cmd_t'(command);

        if (ph != PH_IDLE) begin
            if (tick) begin
                if (t_left == 16'd0)
                    expd = 1'b1;
                else
                    t_left = t_left - 16'd1;
            end
            pw = tx_gate(rx_empty, tx_full, expd);
            // Every phase except the acknowledge and flush waits gates on the port.
            if (ph != PH_RST_ACK && ph != PH_RST_FLUSH && pw == PW_WAIT && !rx_empty)
                act = ACT_READ;
            case (ph)
                PH_RST_WAIT:
                begin
                    // The reset byte goes out even when the wait expired.
                    if (pw != PW_WAIT) begin
                        act = ACT_WCTRL;
                        pb = BYTE_RESET;
                        ph = PH_RST_ACK;
                    end
                end
                PH_RST_ACK:
                begin
                    if (!rx_empty)
                        act = ACT_READ;
                    if (!rx_empty && rx_byte == BYTE_ACK) begin
                        ph = PH_RST_FLUSH;
                    end
                    else if (expd) begin
                        rst_end = 1'b1;
                        rst_ok = 1'b0;
                    end
                end
                PH_RST_FLUSH:
                begin
                    if (rx_empty) begin
                        rst_end = 1'b1;
                        rst_ok = 1'b1;
                    end
                    else if (expd) begin
                        rst_end = 1'b1;
                        rst_ok = 1'b0;
                    end
                    else begin
                        act = ACT_READ;
                    end
                end
                PH_UART:
                begin
                    if (pw == PW_FAIL) begin
                        done = 1'b1;
                        ok = 1'b0;
                        ph = PH_IDLE;
                    end
                    else if (pw == PW_READY) begin
                        act = ACT_WCTRL;
                        pb = BYTE_UART_MODE;
                        good = 1'b1;
                        if (next_chan(0, ch)) begin
                            chan = ch;
                            step = 3'd0;
                            t_left = data_to;
                            ph = PH_PROG;
                        end
                        else begin
                            done = 1'b1;
                            ok = 1'b1;
                            ph = PH_IDLE;
                        end
                    end
                end
                PH_PROG:
                begin
                    if (pw == PW_FAIL) begin
                        good = 1'b0;
                        done = 1'b1;
                        ok = 1'b0;
                        ph = PH_IDLE;
                    end
                    else if (pw == PW_READY) begin
                        act = ACT_WDATA;
                        if (step == 3'd0) begin
                            pb = ST_PROGRAM | {4'h0, chan};
                            step = 3'd1;
                            t_left = data_to;
                        end
                        else begin
                            pb = {1'b0, init_prog};
                            if (next_chan(int'(chan) + 1, ch)) begin
                                chan = ch;
                                step = 3'd0;
                                t_left = data_to;
                            end
                            else begin
                                done = 1'b1;
                                ok = 1'b1;
                                ph = PH_IDLE;
                            end
                        end
                    end
                end
                PH_CL_NOTES, PH_CL_SOUNDS, PH_CL_CTRL:
                begin
                    if (pw == PW_FAIL) begin
                        // Drop the rest of the close, but still reset the port.
                        good = 1'b0;
                        step = 3'd1;
                        t_left = ctl_to;
                        ph = PH_RST_WAIT;
                    end
                    else if (pw == PW_READY) begin
                        act = ACT_WDATA;
                        reload = 1'b1;
                        if (step == 3'd0) begin
                            pb = ST_CONTROL | {4'h0, chan};
                            step = 3'd1;
                        end
                        else if (step == 3'd1) begin
                            pb = (ph == PH_CL_NOTES) ? CC_NOTES_OFF :
                                 (ph == PH_CL_SOUNDS) ? CC_SOUNDS_OFF : CC_CTRL_OFF;
                            step = 3'd2;
                        end
                        else begin
                            pb = 8'd0;
                            step = 3'd0;
                            if (ph == PH_CL_NOTES) begin
                                ph = PH_CL_SOUNDS;
                            end
                            else if (ph == PH_CL_SOUNDS) begin
                                ph = PH_CL_CTRL;
                            end
                            else if (int'(chan) + 1 < CHANNEL_COUNT && chan < 4'd15) begin
                                chan = chan + 4'd1;
                                ph = PH_CL_NOTES;
                            end
                            else begin
                                step = 3'd1;
                                t_left = ctl_to;
                                ph = PH_RST_WAIT;
                                reload = 1'b0;
                            end
                        end
                        if (reload)
                            t_left = data_to;
                    end
                end
                PH_EVENT:
                begin
                    if (pw != PW_WAIT) begin
                        if (pw == PW_READY) begin
                            act = ACT_WDATA;
                            pb = held;
                        end
                        else begin
                            good = 1'b0;
                        end
                        held_v = 1'b0;
                        if (step[0]) begin
                            done = 1'b1;
                            ok = (pw == PW_READY);
                            in_event = 1'b0;
                            skip_meta = 1'b0;
                        end
                        ph = PH_IDLE;
                    end
                end
                default:
                begin
                    ph = PH_IDLE;
                end
            endcase
            if (rst_end) begin
                // Step zero marks an open; otherwise the reset closes a close.
                if (step == 3'd0) begin
                    if (rst_ok) begin
                        t_left = ctl_to;
                        ph = PH_UART;
                    end
                    else begin
                        done = 1'b1;
                        ok = 1'b0;
                        ph = PH_IDLE;
                    end
                end
                else begin
                    done = 1'b1;
                    ok = rst_ok && good;
                    ph = PH_IDLE;
                end
            end
        end
        else if (c == CMD_OPEN) begin
            acc = 1'b1;
            in_event = 1'b0;
            skip_meta = 1'b0;
            held_v = 1'b0;
            step = 3'd0;
            t_left = ctl_to;
            ph = PH_RST_WAIT;
        end
        else if (c == CMD_CLOSE) begin
            acc = 1'b1;
            in_event = 1'b0;
            skip_meta = 1'b0;
            held_v = 1'b0;
            if (!good) begin
                done = 1'b1;
                ok = 1'b0;
            end
            else begin
                chan = 4'd0;
                step = 3'd0;
                t_left = data_to;
                ph = PH_CL_NOTES;
            end
        end
        else if (c == CMD_EVENT) begin
            acc = 1'b1;
            if (!in_event) begin
                in_event = 1'b1;
                skip_meta = good && byte_value == meta_st;
            end
            if (skip_meta || !good) begin
                if (event_end) begin
                    done = 1'b1;
                    ok = skip_meta;
                    in_event = 1'b0;
                    skip_meta = 1'b0;
                end
            end
            else begin
                held = byte_value;
                held_v = 1'b1;
                step = event_end ? 3'd1 : 3'd0;
                t_left = data_to;
                ph = PH_EVENT;
            end
        end

        r.port_action = act;
        r.port_byte = (act == ACT_WDATA || act == ACT_WCTRL) ? pb : 8'd0;
        r.accepted = acc;
        r.request_done = done;
        r.request_ok = done && ok;
        r.device_good = good;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        res_t want;
        res_t fresh;
        if (!rst_n) begin
            ctl_to = CTL_TIMEOUT_RST;
            data_to = DATA_TIMEOUT_RST;
            meta_st = META_STATUS_RST;
            skip_ch = SKIP_CHAN_RST;
            init_prog = INIT_PROG_RST;
            ph = PH_IDLE;
            t_left = 16'd0;
            chan = 4'd0;
            step = 3'd0;
            good = 1'b0;
            in_event = 1'b0;
            skip_meta = 1'b0;
            held = 8'd0;
            held_v = 1'b0;
            port_access_q.delete();
            pending <= 0;
            seq_idle <= 1'b1;
        end
        else begin
            if (result_valid && result_ready) begin
                if (port_access_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, actual action %0d byte %0d",
                             $time, port_action, port_byte);
                end
                else begin
                    want = port_access_q.pop_front();
                    check_field("port_action", want.port_action, port_action);
                    check_field("port_byte", want.port_byte, port_byte);
                    check_field("accepted", want.accepted, accepted);
                    check_field("request_done", want.request_done, request_done);
                    check_field("request_ok", want.request_ok, request_ok);
                    check_field("device_good", want.device_good, device_good);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CTL_TIMEOUT:  ctl_to = cfg_data;
                    CFG_DATA_TIMEOUT: data_to = cfg_data;
                    CFG_META_STATUS:  meta_st = cfg_data[7:0];
                    CFG_SKIP_CHAN:    skip_ch = cfg_data[3:0];
                    CFG_INIT_PROG:    init_prog = cfg_data[6:0];
                    default:          ;
                endcase
            end
            if (item_valid && item_ready) begin
                advance_sequencer(fresh);
                port_access_q.push_back(fresh);
            end
            pending <= port_access_q.size();
            seq_idle <= (ph == PH_IDLE);
        end
    end

endmodule

### tb/midi_uart_port_sequencer_tb.sv
// ----------------------------------------------------------------------------
// midi_uart_port_sequencer_tb
// Stimulus and verdict for the MIDI UART port sequencer. A host model offers
// open, close and event requests, re-offering each one until the sequencer
// takes it, and pairs every poll with a randomized port status sample. The
// checker instance beside the block predicts and compares every result beat.
// Both channels idle and stall at random, and the configuration changes
// between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module midi_uart_port_sequencer_tb;
    import mups_pkg::*;

    // Effective poll beats in the random part, spread over six settings.
    localparam int RANDOM_BEATS = 1050;
    localparam int SETTINGS_N   = 6;
    // Far above the slowest correct run: a few thousand beats, each with the longest
    // idle stretch on the sender and stall on the receiver that pick_span allows.
    localparam int CYCLE_LIMIT  = 600000;

    // One request as the host sees it.
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       last;
    } host_req_t;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'd0;

    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  command = 2'd0;
    logic [7:0]  byte_value = 8'd0;
    logic        event_end = 1'b0;
    logic        tx_full = 1'b0;
    logic        rx_empty = 1'b1;
    logic [7:0]  rx_byte = 8'd0;
    logic        tick = 1'b0;

    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [1:0]  port_action;
    logic [7:0]  port_byte;
    logic        accepted;
    logic        request_done;
    logic        request_ok;
    logic        device_good;

    int          fail_count;
    int          pending;
    logic        seq_idle;

    int          cycles = 0;
    int          busy_beats = 0;
    logic [7:0]  cur_meta = META_STATUS_RST;

    midi_uart_port_sequencer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .byte_value   (byte_value),
        .event_end    (event_end),
        .tx_full      (tx_full),
        .rx_empty     (rx_empty),
        .rx_byte      (rx_byte),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .port_action  (port_action),
        .port_byte    (port_byte),
        .accepted     (accepted),
        .request_done (request_done),
        .request_ok   (request_ok),
        .device_good  (device_good)
    );

    midi_uart_port_sequencer_chk u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .byte_value   (byte_value),
        .event_end    (event_end),
        .tx_full      (tx_full),
        .rx_empty     (rx_empty),
        .rx_byte      (rx_byte),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .port_action  (port_action),
        .port_byte    (port_byte),
        .accepted     (accepted),
        .request_done (request_done),
        .request_ok   (request_ok),
        .device_good  (device_good),
        .fail_count   (fail_count),
        .pending      (pending),
        .seq_idle     (seq_idle)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the handshakes never complete.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Longest idle stretch for a while: none, short or long.
    function automatic int pick_span();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 13;
        endcase
    endfunction

    // Offer one poll beat and hold it until it is taken. The checker's idle
    // flag still shows the state before this edge, which is the state that
    // decides whether the request in this beat is taken. Polls that find the
    // sequencer idle do nothing and are not counted.
    task automatic send_item(input cmd_t c, input logic [7:0] bv, input logic ev_end,
                             input logic txf, input logic rxe, input logic [7:0] rxb,
                             input logic tk, output logic took);
        item_valid <= 1'b1;
        command    <= c;
        byte_value <= bv;
        event_end  <= ev_end;
        tx_full    <= txf;
        rx_empty   <= rxe;
        rx_byte    <= rxb;
        tick       <= tk;
        do
            @(posedge clk);
        while (!item_ready);
        took = seq_idle && c != CMD_POLL;
        if (!(seq_idle && c == CMD_POLL))
            busy_beats++;
    endtask

    // Stop sending and wait until every predicted result beat has arrived,
    // then let the pipeline settle with some margin.
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Configuration writes hold cfg_valid high from one beat to the next;
    // the caller drops it after the last one.
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [15:0] ctl, input logic [15:0] data,
                                 input logic [7:0] meta, input logic [3:0] skip,
                                 input logic [6:0] prog);
        wait_drained();
        write_reg(CFG_CTL_TIMEOUT, ctl);
        write_reg(CFG_DATA_TIMEOUT, data);
        write_reg(CFG_META_STATUS, {8'h00, meta});
        write_reg(CFG_SKIP_CHAN, {12'h000, skip});
        write_reg(CFG_INIT_PROG, {9'h000, prog});
        cfg_valid <= 1'b0;
        cur_meta = meta;
    endtask

    // Receiver: before each result beat it draws a stall, with the longest
    // stall itself changing every forty beats.
    initial begin : result_sink
        int stall;
        int beats;
        int sink_max;
        beats = 0;
        sink_max = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (beats % 40 == 0)
                sink_max = pick_span();
            stall = $urandom_range(0, sink_max);
            if (stall > 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_valid && result_ready));
            beats++;
        end
    end

    initial begin : stimulus
        host_req_t req_q[$];
        host_req_t req;
        logic      from_host;
        logic      took;
        int        pick;
        int        nbytes;
        int        gap;
        int        sent;
        int        send_max;
        int        p_rx;
        int        p_tx;
        int        p_tick;

        sent = 0;
        send_max = 0;
        p_rx = 20;
        p_tx = 25;
        p_tick = 50;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with tight timeouts, so that expiries come quickly.
        // Meta status is 0xF0, and skipped channel 0 makes the first program change
        // go to channel 1.
        apply_setting(16'd2, 16'd1, 8'hF0, 4'd0, 7'h55);
        // Poll while idle, every status bit set: nothing happens.
        send_item(CMD_POLL,  8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b1, took);
        // Event while the device is not good: dropped, and the last byte
        // ends it with a failure.
        send_item(CMD_EVENT, 8'hF0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, took);
        send_item(CMD_EVENT, 8'h7F, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, took);
        // Close while not good: done at once, nothing written.
        send_item(CMD_CLOSE, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, took);
        // Open: drain a byte, wait on a full transmitter, write the reset.
        send_item(CMD_OPEN,  8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, took);
        // A request while busy is refused; a stray byte is read.
        send_item(CMD_EVENT, 8'h80, 1'b1, 1'b0, 1'b0, 8'h12, 1'b0, took);
        // Acknowledge, flush one byte, enter UART mode.
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b0, BYTE_ACK, 1'b0, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b0, 8'hAA, 1'b0, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, took);
        // First program change status byte, then a data timeout that clears
        // the good flag in the middle of the open.
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, took);
        // Open whose reset is never acknowledged.
        send_item(CMD_OPEN,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, took);
        send_item(CMD_POLL,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, took);
        // Single-byte event after the failed open.
        send_item(CMD_EVENT, 8'h55, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, took);

        busy_beats = 0;
        for (int setting = 0; setting < SETTINGS_N; setting++) begin
            // Reset values, both extremes, then random settings.
            case (setting)
                0: apply_setting(CTL_TIMEOUT_RST, DATA_TIMEOUT_RST, META_STATUS_RST,
                                 SKIP_CHAN_RST, INIT_PROG_RST);
                1: apply_setting(16'd1, 16'd1, 8'h00, 4'd0, 7'd0);
                2: apply_setting(16'hFFFF, 16'hFFFF, 8'hFF, 4'd15, 7'd127);
                5: apply_setting(16'($urandom_range(100, 400)), 16'($urandom_range(10, 40)),
                                 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                 7'($urandom_range(0, 127)));
                default: apply_setting(16'($urandom_range(2, 30)), 16'($urandom_range(1, 8)),
                                       8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                       7'($urandom_range(0, 127)));
            endcase
            req_q.delete();

            while (busy_beats < (setting + 1) * RANDOM_BEATS / SETTINGS_N) begin
                // Every sixty beats the port behaves differently: how often a
                // byte waits, how often the transmitter is full, how fast the
                // timeout ticks, and how long the sender idles.
                if (sent % 60 == 0) begin
                    case ($urandom_range(0, 3))
                        0:       p_rx = 0;
                        1:       p_rx = 15;
                        2:       p_rx = 40;
                        default: p_rx = 85;
                    endcase
                    case ($urandom_range(0, 2))
                        0:       p_tx = 0;
                        1:       p_tx = 25;
                        default: p_tx = 75;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       p_tick = 0;
                        1:       p_tick = 10;
                        2:       p_tick = 50;
                        default: p_tick = 100;
                    endcase
                    send_max = pick_span();
                end

                // The host keeps a short list of requests. Half of the draws are
                // well-formed events with random bytes; a few events never
                // mark their end, so the next open or close abandons them.
                if (req_q.size() == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) begin
                        req.cmd = CMD_EVENT;
                        nbytes = $urandom_range(1, 3);
                        for (int k = 0; k < nbytes; k++) begin
                            if (k == 0 && $urandom_range(0, 4) == 0)
                                req.data = cur_meta;
                            else
                                req.data = 8'($urandom_range(0, 255));
                            req.last = (k == nbytes - 1) && ($urandom_range(0, 9) != 0);
                            req_q.push_back(req);
                        end
                    end
                    else begin
                        req.data = 8'($urandom_range(0, 255));
                        req.last = 1'($urandom_range(0, 1));
                        if (pick < 63) begin
                            req.cmd = CMD_OPEN;
                            req_q.push_back(req);
                        end
                        else if (pick < 72) begin
                            req.cmd = CMD_CLOSE;
                            req_q.push_back(req);
                        end
                        else begin
                            req.cmd = CMD_POLL;
                            repeat ($urandom_range(1, 6)) req_q.push_back(req);
                        end
                    end
                end

                // A small share of beats carry a request out of nowhere.
                if ($urandom_range(0, 99) < 5) begin
                    req.cmd = cmd_t'($urandom_range(0, 3));
                    req.data = 8'($urandom_range(0, 255));
                    req.last = 1'($urandom_range(0, 1));
                    from_host = 1'b0;
                end
                else begin
                    req = req_q[0];
                    from_host = 1'b1;
                end

                send_item(req.cmd, req.data, req.last,
                          $urandom_range(0, 99) < p_tx,
                          $urandom_range(0, 99) >= p_rx,
                          ($urandom_range(0, 1) == 0) ? BYTE_ACK : 8'($urandom_range(0, 255)),
                          $urandom_range(0, 99) < p_tick,
                          took);
                sent++;
                // A refused request is offered again on a later beat.
                if (from_host && (took || req.cmd == CMD_POLL))
                    void'(req_q.pop_front());

                gap = $urandom_range(0, send_max);
                if (gap > 0) begin
                    item_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                // Now and then the host stops until everything has come back.
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/mups_pkg.sv
hw/rtl/mups_front.sv
hw/rtl/mups_queue.sv
hw/rtl/mups_back.sv
hw/rtl/midi_uart_port_sequencer.sv
hw/rtl/mups_checker.sv
tb/midi_uart_port_sequencer_chk.sv
tb/midi_uart_port_sequencer_tb.sv
